// ===== hdl/spwq_pkg.sv =====
// Shared types and constants for the sorted priority wait queue.
`timescale 1ns / 1ps

package spwq_pkg;

    localparam int DEPTH = 16;
    localparam int ID_W  = 6;
    localparam int PRI_W = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // One queue slot
    typedef struct packed {
        logic             used;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Operation broadcast to every cell in the accepting cycle
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic             pop;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } op_t;

endpackage

// ===== hdl/sorted_priority_wait_queue.sv =====
// Top level: sorted priority wait queue built as a shifting chain of slot cells.
// Each result is registered: it appears on the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while the output register is free or draining; each item
// updates the whole cell chain through the neighbor shift and the search ripple along the chain.
// Reset clears every slot's used bit, the entry count and the output valid;
// slot ids and priorities are not reset and are only read once written.
`timescale 1ns / 1ps

module sorted_priority_wait_queue
    import spwq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // entry_id[5:0], priority_req[13:6], zero fill
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // popped_valid, popped_id, popped_priority,
                                   // front_valid, front_id, front_priority, count, zero fill
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int OUT_BITS = 1 + ID_W + PRI_W + 1 + ID_W + PRI_W + CNT_W;

    entry_t             cell_q    [DEPTH];
    entry_t             cell_next [DEPTH];
    logic   [DEPTH:0]   take_chain;
    logic   [DEPTH:0]   hit_chain;
    op_t                op;

    logic               in_accept;
    cmd_t               cmd;
    logic [ID_W-1:0]    in_id;
    logic [PRI_W-1:0]   in_pri;
    logic               dup;
    logic               full;
    logic               empty;
    status_t            status;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic [39:0]        m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;
    logic [OUT_BITS-1:0] out_pack;
    logic               popped_valid;
    logic [ID_W-1:0]    popped_id;
    logic [PRI_W-1:0]   popped_pri;

    // Unpack the input item
    assign cmd    = cmd_t'(s_tuser);
    assign in_id  = s_tdata[ID_W-1:0];
    assign in_pri = s_tdata[ID_W +: PRI_W];

    // Take a new item whenever the output register is free or draining
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign dup   = hit_chain[DEPTH];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Decide the operation and its status
    always_comb begin
        op        = '0;
        op.id     = in_id;
        op.pri    = in_pri;
        status    = ST_INVALID;
        case (cmd)
            CMD_INSERT: begin
                if (dup) begin
                    status = ST_INVALID;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    status    = ST_OK;
                    op.insert = in_accept;
                end
            end
            CMD_REMOVE: begin
                if (dup) begin
                    status    = ST_OK;
                    op.remove = in_accept;
                end else begin
                    status = ST_INVALID;
                end
            end
            CMD_POP: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    status = ST_OK;
                    op.pop = in_accept;
                end
            end
            default: begin
                status = ST_INVALID;
            end
        endcase
    end

    // Chain ends: a full virtual slot on the left, an empty one on the right
    assign take_chain[0] = 1'b0;
    assign hit_chain[0]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t left_q, right_q;

        if (i == 0) begin : g_first
            assign left_q = '{used: 1'b1, id: '0, pri: '0};
        end else begin : g_mid_l
            assign left_q = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_q = '0;
        end else begin : g_mid_r
            assign right_q = cell_q[i+1];
        end

        spwq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (op),
            .left_q   (left_q),
            .right_q  (right_q),
            .take_in  (take_chain[i]),
            .take_out (take_chain[i+1]),
            .hit_in   (hit_chain[i]),
            .hit_out  (hit_chain[i+1]),
            .q        (cell_q[i]),
            .q_next   (cell_next[i])
        );
    end

    // Track the entry count
    always_comb begin
        count_next = count_reg;
        if (op.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.remove || op.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Build the result from the front slot before and after the operation
    assign popped_valid = op.pop;
    assign popped_id    = op.pop ? cell_q[0].id  : '0;
    assign popped_pri   = op.pop ? cell_q[0].pri : '0;

    always_comb begin
        out_pack = {count_next,
                    cell_next[0].used ? cell_next[0].pri : {PRI_W{1'b0}},
                    cell_next[0].used ? cell_next[0].id  : {ID_W{1'b0}},
                    cell_next[0].used,
                    popped_pri,
                    popped_id,
                    popped_valid};
    end

    // Hold the result until taken, load a new one on accept
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = 40'(out_pack);
            m_user_next  = status;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hdl/spwq_cell.sv =====
// One slot of the sorted queue chain with its neighbor shift logic.
`timescale 1ns / 1ps

module spwq_cell
    import spwq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  op_t    op,
    input  entry_t left_q,
    input  entry_t right_q,
    input  logic   take_in,
    output logic   take_out,
    input  logic   hit_in,
    output logic   hit_out,
    output entry_t q,
    output entry_t q_next
);

    logic             used_reg, used_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [PRI_W-1:0] pri_reg, pri_next;
    logic             match;
    logic             take;

    assign q = '{used: used_reg, id: id_reg, pri: pri_reg};

    // Flag a slot holding the requested id and pass the hit down the chain
    assign match   = used_reg && (id_reg == op.id);
    assign hit_out = hit_in | match;

    // First free slot or first slot of strictly larger value takes the new entry
    assign take     = !used_reg || (op.pri < pri_reg);
    assign take_out = take_in | take;

    // Select shift from left, load new, shift from right or hold
    always_comb begin
        q_next = q;
        if (op.insert) begin
            if (take_in) begin
                q_next = left_q;
            end else if (take) begin
                q_next = '{used: 1'b1, id: op.id, pri: op.pri};
            end
        end else if (op.remove && hit_out) begin
            q_next = right_q;
        end else if (op.pop) begin
            q_next = right_q;
        end
    end

    assign used_next = q_next.used;
    assign id_next   = q_next.id;
    assign pri_next  = q_next.pri;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

endmodule

// ===== dv/sorted_priority_wait_queue_test.sv =====
// Self-checking testbench for the sorted priority wait queue stream block.
`timescale 1ns / 1ps

module sorted_priority_wait_queue_test
    import spwq_pkg::*;
;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1980;
    localparam int         HOLD_AT      = 450;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 200000;

    // One queued waiter as the predictor keeps it
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } waiter_t;

    // One result item, field by field
    typedef struct packed {
        status_t          status;
        logic             popped_valid;
        logic [ID_W-1:0]  popped_id;
        logic [PRI_W-1:0] popped_pri;
        logic             front_valid;
        logic [ID_W-1:0]  front_id;
        logic [PRI_W-1:0] front_pri;
        logic [CNT_W-1:0] count;
    } outcome_t;

    // One row of the directed stimulus table
    typedef struct {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        bit               typed;
        outcome_t         want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    waiter_t  waiters[$];
    outcome_t pending_results[$];
    int       mismatches  = 0;
    int       items_fed   = 0;
    int       cycle_count = 0;
    bit       steady      = 1'b0;
    outcome_t got_result;
    outcome_t want_result;

    sorted_priority_wait_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Return the slot of a queued id, or -1
    function automatic int find_waiter(logic [ID_W-1:0] id);
        foreach (waiters[i])
            if (waiters[i].id == id)
                return i;
        return -1;
    endfunction

    // Apply one wait queue operation and return the result it reports
    function automatic outcome_t apply_wait_op(logic [1:0] cmd, logic [ID_W-1:0] id,
                                               logic [PRI_W-1:0] pri);
        outcome_t r;
        waiter_t  w;
        int       hit;
        int       pos;
        r = '0;
        r.status = ST_OK;
        hit = find_waiter(id);
        case (cmd)
            CMD_INSERT: begin
                if (hit >= 0) begin
                    r.status = ST_INVALID;
                end else if (waiters.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // land behind every waiter of equal or lower value
                    pos = 0;
                    while (pos < waiters.size() && !(pri < waiters[pos].pri))
                        pos++;
                    w.id  = id;
                    w.pri = pri;
                    waiters.insert(pos, w);
                end
            end
            CMD_REMOVE: begin
                if (hit < 0)
                    r.status = ST_INVALID;
                else
                    waiters.delete(hit);
            end
            CMD_POP: begin
                if (waiters.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_valid = 1'b1;
                    r.popped_id    = waiters[0].id;
                    r.popped_pri   = waiters[0].pri;
                    waiters.delete(0);
                end
            end
            default: r.status = ST_INVALID;
        endcase
        if (waiters.size() > 0) begin
            r.front_valid = 1'b1;
            r.front_id    = waiters[0].id;
            r.front_pri   = waiters[0].pri;
        end
        r.count = CNT_W'(waiters.size());
        return r;
    endfunction

    // Result with nothing popped, for rows whose outcome is obvious
    function automatic outcome_t plain_result(status_t st, logic fv, logic [ID_W-1:0] fid,
                                              logic [PRI_W-1:0] fpri, int cnt);
        outcome_t r;
        r = '0;
        r.status      = st;
        r.front_valid = fv;
        r.front_id    = fid;
        r.front_pri   = fpri;
        r.count       = CNT_W'(cnt);
        return r;
    endfunction

    function automatic stim_row_t step_row(logic [1:0] cmd, logic [ID_W-1:0] id,
                                           logic [PRI_W-1:0] pri, bit typed = 1'b0,
                                           outcome_t want = '0);
        stim_row_t r;
        r.cmd   = cmd;
        r.id    = id;
        r.pri   = pri;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic string show(outcome_t r);
        return $sformatf("st=%0d pv=%0d pid=%0d ppri=%0d fv=%0d fid=%0d fpri=%0d cnt=%0d",
                         r.status, r.popped_valid, r.popped_id, r.popped_pri,
                         r.front_valid, r.front_id, r.front_pri, r.count);
    endfunction

    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(3))
            0: return PRI_W'($urandom_range(3));
            1: return $urandom_range(1) ? {PRI_W{1'b1}} : '0;
            default: return PRI_W'($urandom_range(255));
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one item after a random gap (none while steady), then record what it must return
    task automatic feed_item(logic [1:0] cmd, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                             bit typed, outcome_t typed_want);
        outcome_t want;
        while (!steady && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pri, id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = apply_wait_op(cmd, id, pri);
        if (typed)
            want = typed_want;
        pending_results.push_back(want);
        items_fed++;
        @(negedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && items_fed >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status       = status_t'(m_tuser);
            got_result.popped_valid = m_tdata[0];
            got_result.popped_id    = m_tdata[6:1];
            got_result.popped_pri   = m_tdata[14:7];
            got_result.front_valid  = m_tdata[15];
            got_result.front_id     = m_tdata[21:16];
            got_result.front_pri    = m_tdata[29:22];
            got_result.count        = m_tdata[34:30];
            if (pending_results.size() == 0) begin
                note_mismatch({"result with nothing expected: ", show(got_result)});
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.status !== want_result.status ||
                    got_result.popped_valid !== want_result.popped_valid ||
                    got_result.popped_id !== want_result.popped_id ||
                    got_result.popped_pri !== want_result.popped_pri ||
                    got_result.front_valid !== want_result.front_valid ||
                    got_result.front_id !== want_result.front_id ||
                    got_result.front_pri !== want_result.front_pri ||
                    got_result.count !== want_result.count)
                    note_mismatch({"expected ", show(want_result),
                                   " got ", show(got_result)});
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        stim_row_t        plan[$];
        logic [PRI_W-1:0] fill_pri[13];
        logic [1:0]       cmd;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        bit               filling;
        int               roll;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_POP;
        fill_pri = '{8'd128, 8'd255, 8'd1, 8'd254, 8'd128, 8'd0, 8'd64,
                     8'd200, 8'd3, 8'd128, 8'd17, 8'd90, 8'd255};
        filling  = 1'b0;

        // Hold reset, then release it away from the active edge
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: empty queue, extremes, ties, full queue, bad codes
        plan.push_back(step_row(CMD_POP, 6'd0, 8'd0, 1'b1,
                                plain_result(ST_EMPTY, 1'b0, 6'd0, 8'd0, 0)));
        plan.push_back(step_row(CMD_REMOVE, 6'd5, 8'd0, 1'b1,
                                plain_result(ST_INVALID, 1'b0, 6'd0, 8'd0, 0)));
        plan.push_back(step_row(CMD_INSERT, 6'd0, 8'd255, 1'b1,
                                plain_result(ST_OK, 1'b1, 6'd0, 8'd255, 1)));
        plan.push_back(step_row(CMD_INSERT, 6'd63, 8'd0, 1'b1,
                                plain_result(ST_OK, 1'b1, 6'd63, 8'd0, 2)));
        plan.push_back(step_row(CMD_INSERT, 6'd1, 8'd0));
        for (int k = 0; k < 13; k++)
            plan.push_back(step_row(CMD_INSERT, ID_W'(k + 2), fill_pri[k]));
        plan.push_back(step_row(CMD_INSERT, 6'd63, 8'd5, 1'b1,
                                plain_result(ST_INVALID, 1'b1, 6'd63, 8'd0, 16)));
        plan.push_back(step_row(CMD_INSERT, 6'd40, 8'd9, 1'b1,
                                plain_result(ST_FULL, 1'b1, 6'd63, 8'd0, 16)));
        plan.push_back(step_row(CMD_UNUSED, 6'd10, 8'd0, 1'b1,
                                plain_result(ST_INVALID, 1'b1, 6'd63, 8'd0, 16)));
        plan.push_back(step_row(CMD_REMOVE, 6'd7, 8'd0));
        plan.push_back(step_row(CMD_REMOVE, 6'd63, 8'd0));
        plan.push_back(step_row(CMD_POP, 6'd0, 8'd0));
        foreach (plan[i])
            feed_item(plan[i].cmd, plan[i].id, plan[i].pri, plan[i].typed, plan[i].want);

        // Random part: alternate fill and drain phases so full and empty both occur
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1000);
            if (n % 120 == 0)
                filling = !filling;
            // Let every outstanding result drain completely once
            if (n == 1400) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending_results.size() != 0)
                    @(negedge aclk);
            end
            roll = $urandom_range(99);
            id   = ID_W'($urandom_range(63));
            pri  = pick_priority();
            if (roll < 4) begin
                cmd = 2'($urandom_range(2));
            end else if (roll < (filling ? 70 : 30)) begin
                cmd = CMD_INSERT;
                if (waiters.size() > 0 && $urandom_range(99) < 15)
                    id = waiters[$urandom_range(waiters.size() - 1)].id;
                else
                    while (find_waiter(id) >= 0)
                        id = ID_W'($urandom_range(63));
            end else if (roll < (filling ? 85 : 65)) begin
                cmd = CMD_REMOVE;
                if (waiters.size() > 0 && $urandom_range(99) < 85)
                    id = waiters[$urandom_range(waiters.size() - 1)].id;
            end else begin
                cmd = CMD_POP;
            end
            feed_item(cmd, id, pri, 1'b0, '0);
        end
        steady = 1'b0;

        // Drain, then allow for the output register latency
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
